>>> hdl/ffd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_pkg: shared constants and types for the fractional feedback delay
// Store geometry, datapath widths, register map and the store write request.
// ----------------------------------------------------------------------------
package ffd_pkg;

    // Store geometry
    localparam int DEPTH    = 65536;
    localparam int CHANNELS = 2;
    localparam int POS_W    = $clog2(DEPTH);
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W   = CH_W + POS_W;

    // Datapath widths
    localparam int SAMPLE_W  = 24;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRY          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH       = 3'd4;

    // Write request into the sample store
    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } store_wr_t;

endpackage

>>> hdl/ffd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_store: sample store for all channels
// One write port and two registered read ports; read data follows the address in the next cycle.
// ----------------------------------------------------------------------------
module ffd_store (
    input  logic                                  clk,
    input  ffd_pkg::store_wr_t                    wr,
    input  logic [ffd_pkg::ADDR_W-1:0]            raddr0,
    input  logic [ffd_pkg::ADDR_W-1:0]            raddr1,
    output logic [ffd_pkg::SAMPLE_W-1:0]          rdata0,
    output logic [ffd_pkg::SAMPLE_W-1:0]          rdata1
);

    localparam int WORDS = 1 << ffd_pkg::ADDR_W;

    logic [ffd_pkg::SAMPLE_W-1:0] mem [WORDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read ports
    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> hdl/ffd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_mul: shared signed multiplier
// Registered 33 x 33 signed product, one result per cycle.
// ----------------------------------------------------------------------------
module ffd_mul (
    input  logic                                  clk,
    input  logic signed [ffd_pkg::MUL_W-1:0]      a,
    input  logic signed [ffd_pkg::MUL_W-1:0]      b,
    output logic signed [ffd_pkg::PROD_W-1:0]     p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

>>> hdl/fractional_feedback_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_feedback_delay: multichannel feedback delay with interpolation
// Output: sample_out is registered, loaded from ST_MIX once the output register is free.
// Throughput: one sample at a time; in_stall stays high through the ten-step
//   schedule on the single shared multiplier (four smoothing steps, interpolation,
//   feedback, two mix products) and while the output stalls.
// Reset: settings return to defaults; the store is then swept to zero, one
//   entry per cycle over all 2^ADDR_W = 131072 entries, with in_stall held high.
// ----------------------------------------------------------------------------
module fractional_feedback_delay (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  channel_index,
    input  logic signed [23:0]                    sample_in,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [23:0]                    sample_out,
    // configuration
    input  logic                                  cfg_we,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ffd_pkg::CFG_W-1:0]             cfg_data
);

    localparam int CH_W     = ffd_pkg::CH_W;
    localparam int POS_W    = ffd_pkg::POS_W;
    localparam int ADDR_W   = ffd_pkg::ADDR_W;
    localparam int CHANNELS = ffd_pkg::CHANNELS;
    localparam int MUL_W    = ffd_pkg::MUL_W;
    localparam int PROD_W   = ffd_pkg::PROD_W;
    localparam int RED_W    = 27;
    localparam int RED_STEPS = 6;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(ffd_pkg::DEPTH - 1);
    localparam logic [POS_W+1:0] DEPTH_X  = (POS_W + 2)'(ffd_pkg::DEPTH);
    localparam logic [RED_W-1:0] DEPTH_R  = RED_W'(ffd_pkg::DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DLY,
        ST_FBK,
        ST_WET,
        ST_DRY,
        ST_FETCH,
        ST_INTERP,
        ST_FBMUL,
        ST_WRITE,
        ST_MIXA,
        ST_MIX
    } state_t;

    // Clamp to the Q1.23 range
    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        logic signed [23:0] r;
        if (v > 28'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -28'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    // Integer delay modulo DEPTH by conditional subtraction of DEPTH * 2^k
    function automatic logic [POS_W-1:0] mod_depth(input logic [15:0] v);
        logic [RED_W-1:0] r;
        r = RED_W'(v);
        for (int k = RED_STEPS - 1; k >= 0; k--)
        begin
            if (r >= (DEPTH_R << k))
                r = r - (DEPTH_R << k);
        end
        return POS_W'(r);
    endfunction

    // Control and settings
    state_t                state_reg;
    logic                  clearing_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  out_valid_reg;
    logic signed [23:0]    sample_out_reg;
    logic [23:0]           tgt_delay_reg;
    logic [14:0]           fb_gain_reg;
    logic [15:0]           wet_gain_reg;
    logic [15:0]           dry_gain_reg;
    logic [15:0]           coef_reg;

    // Per-channel state
    logic [31:0]           sd_reg   [CHANNELS];
    logic [31:0]           sfb_reg  [CHANNELS];
    logic [31:0]           swet_reg [CHANNELS];
    logic [31:0]           sdry_reg [CHANNELS];
    logic [POS_W-1:0]      wp_reg   [CHANNELS];
    logic signed [23:0]    last_reg [CHANNELS];

    // Per-item datapath registers
    logic [CH_W-1:0]       ch_reg;
    logic signed [23:0]    x_reg;
    logic [POS_W-1:0]      sdm_reg;
    logic [15:0]           t_reg;
    logic signed [23:0]    y0_reg;
    logic signed [24:0]    diff_reg;
    logic signed [23:0]    y_reg;
    logic signed [57:0]    mixa_reg;

    // Combinational signals
    logic                      in_take;
    logic                      out_go;
    logic [CH_W-1:0]           ch_in;
    logic [31:0]               sm_s;
    logic [31:0]               sm_tgt;
    logic signed [MUL_W-1:0]   sm_diff;
    logic [31:0]               cons_s;
    logic [31:0]               sm_next;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [POS_W-1:0]          w_cur;
    logic [15:0]               frac;
    logic                      borrow;
    logic [POS_W+1:0]          fi;
    logic [POS_W-1:0]          f_pos;
    logic [POS_W-1:0]          i0_pos;
    logic [15:0]               t_next;
    logic [POS_W-1:0]          wp_next;
    logic signed [23:0]        y_next;
    logic signed [24:0]        diff_next;
    logic signed [23:0]        wr_next;
    logic signed [57:0]        mix_sum;
    logic signed [23:0]        out_next;
    logic [ffd_pkg::SAMPLE_W-1:0] rdata0;
    logic [ffd_pkg::SAMPLE_W-1:0] rdata1;
    logic [ADDR_W-1:0]         raddr0;
    logic [ADDR_W-1:0]         raddr1;
    ffd_pkg::store_wr_t        store_wr;

    // Handshake
    assign in_stall   = (state_reg != ST_IDLE) || clearing_reg;
    assign in_take    = in_valid && !in_stall;
    assign out_go     = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign ch_in      = (CHANNELS > 1) ? CH_W'(channel_index) : '0;

    // Smoothing operands: target and current value for the step being issued
    always_comb
    begin
        case (state_reg)
            ST_DLY:
            begin
                sm_s   = sd_reg[ch_reg];
                sm_tgt = {tgt_delay_reg, 8'b0};
            end
            ST_FBK:
            begin
                sm_s   = sfb_reg[ch_reg];
                sm_tgt = {1'b0, fb_gain_reg, 16'b0};
            end
            ST_WET:
            begin
                sm_s   = swet_reg[ch_reg];
                sm_tgt = {wet_gain_reg, 16'b0};
            end
            ST_DRY:
            begin
                sm_s   = sdry_reg[ch_reg];
                sm_tgt = {dry_gain_reg, 16'b0};
            end
            default:
            begin
                sm_s   = '0;
                sm_tgt = '0;
            end
        endcase
    end

    assign sm_diff = signed'({1'b0, sm_tgt}) - signed'({1'b0, sm_s});

    // Value that the product arriving this cycle updates
    always_comb
    begin
        case (state_reg)
            ST_FBK:   cons_s = sd_reg[ch_reg];
            ST_WET:   cons_s = sfb_reg[ch_reg];
            ST_DRY:   cons_s = swet_reg[ch_reg];
            ST_FETCH: cons_s = sdry_reg[ch_reg];
            default:  cons_s = '0;
        endcase
    end

    // s + floor(c * (target - s) / 2^16), wrapping at 32 bits
    assign sm_next = cons_s + prod[47:16];

    // Multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_DLY, ST_FBK, ST_WET, ST_DRY:
            begin
                mul_a = sm_diff;
                mul_b = signed'({17'b0, coef_reg});
            end
            ST_INTERP:
            begin
                mul_a = MUL_W'(diff_reg);
                mul_b = signed'({17'b0, t_reg});
            end
            ST_FBMUL:
            begin
                mul_a = MUL_W'(last_reg[ch_reg]);
                mul_b = signed'({1'b0, sfb_reg[ch_reg]});
            end
            ST_WRITE:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = signed'({1'b0, sdry_reg[ch_reg]});
            end
            ST_MIXA, ST_MIX:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = signed'({1'b0, swet_reg[ch_reg]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ffd_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Read position: write position minus smoothed delay, modulo the store
    assign w_cur  = wp_reg[ch_reg];
    assign frac   = sd_reg[ch_reg][15:0];
    assign borrow = (frac != 16'd0);
    assign t_next = 16'd0 - frac;
    assign fi     = {2'b00, w_cur} - {2'b00, sdm_reg} - {{(POS_W + 1){1'b0}}, borrow};
    assign f_pos  = fi[POS_W+1] ? POS_W'(fi + DEPTH_X) : fi[POS_W-1:0];
    assign i0_pos = (f_pos == '0) ? POS_LAST : f_pos - POS_W'(1);
    assign raddr1 = {ch_reg, f_pos};
    assign raddr0 = {ch_reg, i0_pos};
    assign wp_next = (w_cur == POS_LAST) ? '0 : w_cur + POS_W'(1);

    // Interpolation, feedback and mix arithmetic
    assign diff_next = signed'(25'(signed'(rdata1))) - signed'(25'(signed'(rdata0)));
    assign y_next    = y0_reg + signed'(prod[39:16]);
    assign wr_next   = sat24(28'(x_reg) + 28'(signed'(prod[56:31])));
    assign mix_sum   = mixa_reg + signed'(prod[57:0]);
    assign out_next  = sat24(28'(signed'(mix_sum[57:31])));

    // Store write: clearing sweep or the feedback write of the current item
    always_comb
    begin
        store_wr.en   = clearing_reg || (state_reg == ST_WRITE);
        store_wr.addr = clearing_reg ? clr_addr_reg : {ch_reg, w_cur};
        store_wr.data = clearing_reg ? '0 : wr_next;
    end

    ffd_store u_store (
        .clk    (clk),
        .wr     (store_wr),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // Sequencer, clearing sweep, settings and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
            tgt_delay_reg  <= 24'd256;
            fb_gain_reg    <= 15'd0;
            wet_gain_reg   <= 16'd0;
            dry_gain_reg   <= 16'd32768;
            coef_reg       <= 16'd656;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ffd_pkg::REG_TARGET_DELAY: tgt_delay_reg <= cfg_data;
                    ffd_pkg::REG_FEEDBACK:     fb_gain_reg   <= cfg_data[14:0];
                    ffd_pkg::REG_WET:          wet_gain_reg  <= cfg_data[15:0];
                    ffd_pkg::REG_DRY:          dry_gain_reg  <= cfg_data[15:0];
                    ffd_pkg::REG_SMOOTH:       coef_reg      <= cfg_data[15:0];
                    default:                   ;
                endcase
            end

            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == '1)
                begin
                    clearing_reg <= 1'b0;
                end
            end

            // Output register: load a finished item, or clear on transfer
            if ((state_reg == ST_MIX) && out_go)
            begin
                out_valid_reg  <= 1'b1;
                sample_out_reg <= out_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:   if (in_take) state_reg <= ST_DLY;
                ST_DLY:    state_reg <= ST_FBK;
                ST_FBK:    state_reg <= ST_WET;
                ST_WET:    state_reg <= ST_DRY;
                ST_DRY:    state_reg <= ST_FETCH;
                ST_FETCH:  state_reg <= ST_INTERP;
                ST_INTERP: state_reg <= ST_FBMUL;
                ST_FBMUL:  state_reg <= ST_WRITE;
                ST_WRITE:  state_reg <= ST_MIXA;
                ST_MIXA:   state_reg <= ST_MIX;
                ST_MIX:    if (out_go) state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Per-channel smoothed values, write positions and last reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sd_reg[i]   <= '0;
                sfb_reg[i]  <= '0;
                swet_reg[i] <= '0;
                sdry_reg[i] <= '0;
                wp_reg[i]   <= '0;
                last_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_FBK:   sd_reg[ch_reg]   <= sm_next;
                ST_WET:   sfb_reg[ch_reg]  <= sm_next;
                ST_DRY:   swet_reg[ch_reg] <= sm_next;
                ST_FETCH: sdry_reg[ch_reg] <= sm_next;
                ST_WRITE: last_reg[ch_reg] <= y_reg;
                ST_MIX:   if (out_go) wp_reg[ch_reg] <= wp_next;
                default:  ;
            endcase
        end
    end

    // Per-item datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    ch_reg <= ch_in;
                    x_reg  <= sample_in;
                end
            end
            ST_WET:   sdm_reg  <= mod_depth(sd_reg[ch_reg][31:16]);
            ST_DRY:   t_reg    <= t_next;
            ST_FETCH:
            begin
                y0_reg   <= signed'(rdata0);
                diff_reg <= diff_next;
            end
            ST_FBMUL: y_reg    <= y_next;
            ST_MIXA:  mixa_reg <= signed'(prod[57:0]);
            default:  ;
        endcase
    end

endmodule
